FILE: rtl/mexp_pkg.sv
// ============================================================================
// mexp_pkg: shared types and constants for the modular exponentiation core
// Holds the field width of the ports, the default operand width, the reset
// value of the modulus register and the controller state type.
// ============================================================================
`default_nettype none

package mexp_pkg;

    // Width of every payload and configuration port
    localparam int FIELD_W = 32;

    // Default operand width of the arithmetic
    localparam int DEFAULT_WIDTH = 32;

    // Modulus register value after reset
    localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SETUP,
        ST_MULT,
        ST_FINISH
    } mexp_state_t;

endpackage : mexp_pkg

`default_nettype wire

FILE: rtl/modular_exponentiation_core.sv
// ============================================================================
// modular_exponentiation_core: right-to-left binary modular exponentiation
// Bit-serial square-and-multiply engine with a restoring base reduction.
// ============================================================================
//
// Usage:
//   Input channel (in_valid / in_ready) carries base_value and exponent. The
//   core takes one item at a time; in_ready is high only while it is free.
//   Output channel (out_valid / out_ready) returns power_result, which is
//   base_value ** exponent mod modulus, or 1 for a zero exponent. A result
//   waits in its own output register, so the next item is accepted while the
//   receiver stalls; a second result waits inside the core until the first
//   one is taken.
//   Configuration: cfg_we writes cfg_wdata into the modulus register. Write
//   only while no item is in flight. Modulus zero gives the power mod 2^WIDTH.
//   The base reduction runs first and is skipped for modulus zero. Then one
//   multiply pass runs per exponent bit up to the highest set bit, none for a
//   zero exponent. The two modular multipliers work through the multiplier
//   bits MSB first (double, then conditional add), and each exponent bit costs
//   one full multiply pass plus a setup step. The core is ready for the next
//   item as soon as the result enters the output register.
//   Reset clears the controller, drops any pending result and sets modulus
//   to 1.
//
// ============================================================================
`default_nettype none

module modular_exponentiation_core #(
    parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_we,
    input  wire logic [mexp_pkg::FIELD_W-1:0] cfg_wdata,
    // input items
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [mexp_pkg::FIELD_W-1:0] base_value,
    input  wire logic [mexp_pkg::FIELD_W-1:0] exponent,
    // result items
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [mexp_pkg::FIELD_W-1:0]      power_result
);
    import mexp_pkg::*;

    // Bits taken from / returned to the fixed-width ports
    localparam int IN_W  = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
    localparam int CNT_W = $clog2(WIDTH);

    // (a + b) mod m for a, b < m; plain wrap when the modulus is zero
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] a,
        input logic [WIDTH-1:0] b,
        input logic [WIDTH-1:0] m,
        input logic             m_zero
    );
        logic [WIDTH:0] sum;
        logic [WIDTH:0] dif;
        sum = {1'b0, a} + {1'b0, b};
        dif = sum - {1'b0, m};
        if (m_zero || (sum < {1'b0, m}))
            return sum[WIDTH-1:0];
        return dif[WIDTH-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    mexp_state_t          state_reg, state_next;
    logic [FIELD_W-1:0]   mod_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]   out_data_reg, out_data_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 phase_reg, phase_next;

    logic [WIDTH-1:0]     b_reg, b_next;       // base power; dividend shifter in reduce
    logic [WIDTH-1:0]     e_reg, e_next;       // exponent, shifted right per bit
    logic [WIDTH-1:0]     r_reg, r_next;       // running result
    logic [WIDTH-1:0]     rem_reg, rem_next;   // partial remainder of the reduction
    logic [WIDTH-1:0]     bsh_reg, bsh_next;   // multiplier bit stream, MSB first
    logic [WIDTH-1:0]     acc_r_reg, acc_r_next;
    logic [WIDTH-1:0]     acc_s_reg, acc_s_next;

    // ------------------------------------------------------------------
    // Operand views
    // ------------------------------------------------------------------
    logic [WIDTH-1:0]     m_op;
    logic [WIDTH-1:0]     base_op;
    logic [WIDTH-1:0]     exp_op;
    logic                 m_zero;
    logic                 last_step;
    logic                 in_fire;
    logic                 out_free;

    always_comb
    begin
        m_op    = '0;
        base_op = '0;
        exp_op  = '0;
        m_op[IN_W-1:0]    = mod_reg[IN_W-1:0];
        base_op[IN_W-1:0] = base_value[IN_W-1:0];
        exp_op[IN_W-1:0]  = exponent[IN_W-1:0];
    end

    assign m_zero    = (m_op == '0);
    assign last_step = (cnt_reg == CNT_W'(WIDTH - 1));
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    // Output register can take a new result this cycle
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign power_result = out_data_reg;

    // ------------------------------------------------------------------
    // Arithmetic steps
    // ------------------------------------------------------------------
    logic [WIDTH:0]       div_try;
    logic [WIDTH:0]       div_d;
    logic [WIDTH-1:0]     rem_step;
    logic [WIDTH-1:0]     dbl_r, dbl_s, add_r, add_s;
    logic [WIDTH-1:0]     acc_r_step, acc_s_step;

    always_comb
    begin
        // Restoring division step: shift in next dividend bit, subtract if fits
        div_try  = {rem_reg, b_reg[WIDTH-1]};
        div_d    = div_try - {1'b0, m_op};
        rem_step = (div_try >= {1'b0, m_op}) ? div_d[WIDTH-1:0] : div_try[WIDTH-1:0];

        // Two multipliers share the bit stream of the current base power:
        // r * b for the result and b * b for the next power
        dbl_r = add_mod(acc_r_reg, acc_r_reg, m_op, m_zero);
        dbl_s = add_mod(acc_s_reg, acc_s_reg, m_op, m_zero);
        add_r = add_mod(acc_r_reg, r_reg, m_op, m_zero);
        add_s = add_mod(acc_s_reg, b_reg, m_op, m_zero);

        if (!phase_reg)
        begin
            acc_r_step = dbl_r;
            acc_s_step = dbl_s;
        end
        else if (bsh_reg[WIDTH-1])
        begin
            acc_r_step = add_r;
            acc_s_step = add_s;
        end
        else
        begin
            acc_r_step = acc_r_reg;
            acc_s_step = acc_s_reg;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = m_zero ? ST_SETUP : ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (last_step)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = (e_reg == '0) ? ST_FINISH : ST_MULT;
            end
            ST_MULT:
            begin
                if (phase_reg && last_step)
                    state_next = ST_SETUP;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        b_next        = b_reg;
        e_next        = e_reg;
        r_next        = r_reg;
        rem_next      = rem_reg;
        bsh_next      = bsh_reg;
        acc_r_next    = acc_r_reg;
        acc_s_next    = acc_s_reg;
        cnt_next      = cnt_reg;
        phase_next    = phase_reg;
        out_data_next = out_data_reg;

        // Drop the result once the receiver takes it
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    b_next   = base_op;
                    e_next   = exp_op;
                    r_next   = WIDTH'(1);
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            ST_REDUCE:
            begin
                rem_next = rem_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    b_next   = rem_step;
                    cnt_next = '0;
                end
                else
                begin
                    b_next = b_reg << 1;
                end
            end
            ST_SETUP:
            begin
                // Arm both multipliers for the next exponent bit
                acc_r_next = '0;
                acc_s_next = '0;
                bsh_next   = b_reg;
                cnt_next   = '0;
                phase_next = 1'b0;
            end
            ST_MULT:
            begin
                acc_r_next = acc_r_step;
                acc_s_next = acc_s_step;
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    bsh_next = bsh_reg << 1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (last_step)
                    begin
                        // Commit: multiply in on a set exponent bit, always square
                        if (e_reg[0])
                            r_next = acc_r_step;
                        b_next   = acc_s_step;
                        e_next   = e_reg >> 1;
                        cnt_next = '0;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[IN_W-1:0] = r_reg[IN_W-1:0];
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mod_reg       <= MODULUS_RESET;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            if (cfg_we)
                mod_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        e_reg        <= e_next;
        r_reg        <= r_next;
        rem_reg      <= rem_next;
        bsh_reg      <= bsh_next;
        acc_r_reg    <= acc_r_next;
        acc_s_reg    <= acc_s_next;
        out_data_reg <= out_data_next;
    end

endmodule : modular_exponentiation_core

`default_nettype wire

FILE: rtl/mexp_checker.sv
// ============================================================================
// mexp_checker: port-level checks for the modular exponentiation core
// Watches the handshakes of the top level and flags ordering slips.
// ============================================================================
`default_nettype none

module mexp_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [mexp_pkg::FIELD_W-1:0] power_result
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_result))
        else $error("result changed or dropped while stalled");

    // One item at a time: in_ready stays low after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("core took a second item while busy");

    // A new result appears exactly as the core turns free
    a_result_frees_core: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready && !$past(in_ready))
        else $error("result appeared without the core finishing");

endmodule : mexp_checker

bind modular_exponentiation_core mexp_checker u_mexp_checker (.*);

`default_nettype wire

FILE: sim/modexp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modexp_checker: result checker for the modular exponentiation core
// Tracks the modulus register, predicts one power per accepted item and
// compares each returned result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------

module modexp_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [mexp_pkg::FIELD_W-1:0] cfg_wdata,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [mexp_pkg::FIELD_W-1:0] base_value,
    input  logic [mexp_pkg::FIELD_W-1:0] exponent,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [mexp_pkg::FIELD_W-1:0] power_result,
    output int                           fail_count,
    output int                           due_count
);
    import mexp_pkg::*;

    localparam int W = FIELD_W;

    typedef struct {
        logic [W-1:0] base;
        logic [W-1:0] expo;
        logic [W-1:0] modv;
        logic [W-1:0] power;
    } power_job_t;

    power_job_t   power_due[$];
    logic [W-1:0] modulus_q   = MODULUS_RESET;
    int           mismatches  = 0;
    int           outstanding = 0;

    assign fail_count = mismatches;
    assign due_count  = outstanding;

    // Modulus zero means plain wrap at the operand width
    function automatic logic [63:0] reduce_product(input logic [63:0] a,
                                                   input logic [63:0] b,
                                                   input logic [W-1:0] modv);
        logic [63:0] prod;
        begin
            prod = a * b;
            if (modv != 0)
                return prod % modv;
            return prod & 64'hFFFF_FFFF;
        end
    endfunction

    // Right-to-left square and multiply; a zero exponent leaves the 1 untouched
    function automatic logic [W-1:0] mod_power(input logic [W-1:0] base_in,
                                               input logic [W-1:0] exp_in,
                                               input logic [W-1:0] modv);
        logic [63:0]  acc;
        logic [63:0]  sq;
        logic [W-1:0] e;
        begin
            sq  = (modv != 0) ? (base_in % modv) : base_in;
            acc = 64'd1;
            e   = exp_in;
            while (e != 0)
            begin
                if (e[0])
                    acc = reduce_product(acc, sq, modv);
                sq = reduce_product(sq, sq, modv);
                e  = e >> 1;
            end
            return acc[W-1:0];
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        power_job_t job;
        if (!rst_n)
        begin
            modulus_q <= MODULUS_RESET;
            power_due.delete();
            outstanding <= 0;
        end
        else
        begin
            // retire first: a result can never belong to an item taken this edge
            if (out_valid && out_ready)
            begin
                if (power_due.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, power_result);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    job = power_due.pop_front();
                    if (power_result !== job.power)
                    begin
                        $display({"%0t: power_result mismatch (base %h exp %h mod %h): ",
                                  "expected %h, actual %h"},
                                 $time, job.base, job.expo, job.modv, job.power,
                                 power_result);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                job.base  = base_value;
                job.expo  = exponent;
                job.modv  = modulus_q;
                job.power = mod_power(base_value, exponent, modulus_q);
                power_due.push_back(job);
            end
            if (cfg_we)
                modulus_q <= cfg_wdata;
            outstanding <= power_due.size();
        end
    end

endmodule

FILE: sim/modular_exponentiation_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core_tb: stimulus and verdict for the exponent core
// Runs a directed set of edge cases under several moduli, then random phases
// with bursty input and a stalling receiver. All checking is done by the
// checker instance; this module drives items and reports the outcome.
// ----------------------------------------------------------------------------

module modular_exponentiation_core_tb;
    import mexp_pkg::*;

    localparam int W            = FIELD_W;
    // Watchdog bound for the whole run
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 245;
    // Long receiver hold-off: longer than two worst-case items, so the output
    // register and the core both fill and in_ready must drop
    localparam int HOLD_CYCLES  = 6000;
    // Start the hold inside the directed run under the largest modulus, where
    // the sender keeps offering items without pausing for a drain
    localparam int HOLD_AFTER   = 7;
    // Quiet time after the last result, about one worst-case item
    localparam int TAIL_CYCLES  = 2200;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [W-1:0] cfg_wdata;
    logic         in_valid;
    logic         in_ready;
    logic [W-1:0] base_value;
    logic [W-1:0] exponent;
    logic         out_valid;
    logic         out_ready;
    logic [W-1:0] power_result;

    int           fail_count;
    int           due_count;

    int           cycle_count    = 0;
    int           accepted_items = 0;
    int           burst_left     = 0;
    logic [W-1:0] modulus_now    = MODULUS_RESET;

    modular_exponentiation_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_value   (base_value),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_result (power_result)
    );

    modexp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .base_value   (base_value),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .power_result (power_result),
        .fail_count   (fail_count),
        .due_count    (due_count)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if the block stops making progress
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("modular_exponentiation_core_tb NOT OK");
        $finish;
    end

    // Offer one item; valid stays high across back-to-back items in a burst
    // and drops only when a gap starts. Returns at the accepting edge.
    task automatic push_item(input logic [W-1:0] b, input logic [W-1:0] e);
        int gap;
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                // mostly short gaps, now and then one long enough to land
                // in the middle of a multiply pass
                if ($urandom_range(0, 7) == 0)
                    gap = $urandom_range(100, 1500);
                else
                    gap = $urandom_range(1, 30);
                repeat (gap) @(posedge clk);
                // a long burst now and then keeps the input busy without gaps
                if ($urandom_range(0, 3) == 0)
                    burst_left = $urandom_range(20, 60);
                else
                    burst_left = $urandom_range(1, 6);
            end
            in_valid   <= 1'b1;
            base_value <= b;
            exponent   <= e;
            do
                @(posedge clk);
            while (!in_ready);
            burst_left--;
            accepted_items++;
        end
    endtask

    // Drop valid and hold until every predicted result has come back.
    // Check after an edge so an item taken at this edge is already counted.
    task automatic drain_results();
        begin
            in_valid  <= 1'b0;
            burst_left = 0;
            do
                @(posedge clk);
            while (due_count != 0);
        end
    endtask

    // Write the modulus only with the block idle
    task automatic set_modulus(input logic [W-1:0] value);
        begin
            drain_results();
            cfg_we      <= 1'b1;
            cfg_wdata   <= value;
            modulus_now  = value;
            @(posedge clk);
            cfg_we      <= 1'b0;
        end
    endtask

    // Exponent of random bit length, from zero up to full width with the top bit
    // set, so short and long exponents mix and every exponent bit toggles
    function automatic logic [W-1:0] pick_exponent();
        int          len;
        logic [63:0] e;
        begin
            len = $urandom_range(0, W);
            if (len == 0)
                return '0;
            e = {32'd0, $urandom} & ((64'd1 << len) - 64'd1);
            e[len-1] = 1'b1;
            return e[W-1:0];
        end
    endfunction

    // Bases near the reduction boundary show up often
    function automatic logic [W-1:0] pick_base(input logic [W-1:0] modv);
        begin
            case ($urandom_range(0, 7))
                0:       return '0;
                1:       return 32'd1;
                2:       return modv - 32'd1;
                3:       return modv;
                4:       return modv + 32'd1;
                default: return $urandom;
            endcase
        end
    endfunction

    function automatic logic [W-1:0] pick_modulus();
        begin
            case ($urandom_range(0, 9))
                0:       return 32'd1;
                1:       return 32'd1 << $urandom_range(1, 31);
                2, 3:    return $urandom_range(2, 300);
                4:       return $urandom | 32'h8000_0000;
                5:       return 32'hFFFF_FFFF - $urandom_range(0, 64);
                default: return $urandom_range(1, 32'hFFFF_FFFF);
            endcase
        end
    endfunction

    // Receiver: stall pattern changes every stretch; one long hold-off while
    // the sender keeps offering, so the block backs up and stalls its input
    initial
    begin : receiver
        int   stretch_left;
        int   stall_mode;
        logic hold_done;
        stretch_left = 0;
        stall_mode   = 0;
        hold_done    = 1'b0;
        out_ready    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && accepted_items >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (stretch_left == 0)
            begin
                stall_mode   = $urandom_range(0, 3);
                stretch_left = $urandom_range(20, 300);
            end
            stretch_left--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 15) == 0);
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int n;
        int random_sent;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        base_value = '0;
        exponent   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset modulus is 1: zero exponent still gives 1, anything else 0
        push_item(32'd5, 32'd0);
        push_item(32'd0, 32'd0);
        push_item(32'd7, 32'd3);
        push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Largest modulus: operand extremes and base equal to the modulus
        set_modulus(32'hFFFF_FFFF);
        push_item(32'd0, 32'd0);
        push_item(32'd0, 32'd5);
        push_item(32'hFFFF_FFFF, 32'd0);
        push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(32'hFFFF_FFFE, 32'd2);
        push_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        push_item(32'd2, 32'd31);
        push_item(32'd2, 32'd32);
        push_item(32'd1, 32'hFFFF_FFFF);
        push_item(32'h8000_0001, 32'h8000_0000);

        // Modulus zero: no reduction, power wraps at the operand width
        set_modulus(32'd0);
        push_item(32'd3, 32'd5);
        push_item(32'hFFFF_FFFF, 32'd2);
        push_item(32'd2, 32'd32);
        push_item(32'd7, 32'd0);
        push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Smallest even modulus and a small prime
        set_modulus(32'd2);
        push_item(32'd3, 32'd1);
        push_item(32'd5, 32'hFFFF_FFFF);
        set_modulus(32'd13);
        push_item(32'd12, 32'hFFFF_FFFF);
        push_item(32'd26, 32'd7);

        // Modulus written back to 1 explicitly
        set_modulus(32'd1);
        push_item(32'd9, 32'd9);
        push_item(32'd9, 32'd0);

        // Random phases, each with a fresh modulus written while idle
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            set_modulus(pick_modulus());
            n = $urandom_range(20, 40);
            if (n > RANDOM_ITEMS - random_sent)
                n = RANDOM_ITEMS - random_sent;
            repeat (n)
            begin
                push_item(pick_base(modulus_now), pick_exponent());
                random_sent++;
            end
        end

        // Let everything drain, then watch for stray results
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("modular_exponentiation_core_tb OK");
        else
            $display("modular_exponentiation_core_tb NOT OK");
        $finish;
    end

endmodule
